/* rtl/core/ssp_pkg.sv */
package ssp_pkg;

  localparam int MAX_NODES_DEF = 64;
  localparam int MAX_EDGES_DEF = 256;

  localparam int NODE_W  = 6;
  localparam int COUNT_W = 7;
  localparam int COST_W  = 16;
  localparam int DIST_W  = 32;
  localparam int IN_W    = 32;
  localparam int OUT_W   = 40;
  localparam int EDGE_W  = 2 * NODE_W + COST_W;

  // Input command codes as they arrive on the stream.
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_RUN    = 2'd2;
  localparam logic [1:0] CMD_NONE   = 2'd3;

  // Register indexes on the configuration port.
  localparam logic REG_NODE_COUNT = 1'b0;
  localparam logic REG_START_NODE = 1'b1;

  localparam logic [COUNT_W-1:0] NODE_COUNT_RST = COUNT_W'(64);

  localparam logic signed [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
  localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

  typedef struct packed {
    logic [1:0]               op;
    logic [NODE_W-1:0]        src;
    logic [NODE_W-1:0]        dst;
    logic signed [COST_W-1:0] weight;
  } cmd_t;

endpackage

/* rtl/core/ssp_ram.sv */
module ssp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/ssp_front.sv */
module ssp_front
  import ssp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_W-1:0]   s_tdata,   // src_node, dst_node, weight, zero pad
  input  logic [1:0]        s_tuser,   // command
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output cmd_t              cmd
);

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;
  cmd_t       incoming;

  assign s_tready = (count != 2'd2);

  // The unused command code CMD_NONE is dropped here and never reaches the back end.
  assign push = s_tvalid && s_tready && (s_tuser != CMD_NONE);
  assign pop  = cmd_valid && cmd_ready;

  always_comb begin
    incoming.op     = s_tuser;
    incoming.src    = s_tdata[NODE_W-1:0];
    incoming.dst    = s_tdata[2*NODE_W-1:NODE_W];
    incoming.weight = s_tdata[EDGE_W-1:2*NODE_W];
  end

  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= incoming;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/core/ssp_back.sv */
module ssp_back
  import ssp_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEF,
  parameter int MAX_EDGES = MAX_EDGES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  cmd_t               cmd,
  input  logic [COUNT_W-1:0] node_count,
  input  logic [NODE_W-1:0]  start_node,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [OUT_W-1:0]   m_tdata,   // node_index, distance, reachable, negative_cycle
  output logic               m_tlast
);

  localparam int NW  = $clog2(MAX_NODES);
  localparam int EAW = MAX_EDGES > 1 ? $clog2(MAX_EDGES) : 1;
  localparam int ETW = $clog2(MAX_EDGES + 1);
  localparam int CW  = ETW + 1;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_PSTART = 4'd1;
  localparam logic [3:0] S_EREAD  = 4'd2;
  localparam logic [3:0] S_NREAD  = 4'd3;
  localparam logic [3:0] S_ADD    = 4'd4;
  localparam logic [3:0] S_CMP    = 4'd5;
  localparam logic [3:0] S_PEND   = 4'd6;
  localparam logic [3:0] S_ERD    = 4'd7;
  localparam logic [3:0] S_ELD    = 4'd8;

  logic [3:0]         state;
  logic [ETW-1:0]     edge_total;
  logic [EAW-1:0]     edge_idx;
  logic [COUNT_W-1:0] n_run;
  logic [COUNT_W-1:0] pass;
  logic [NW-1:0]      emit_idx;
  logic [MAX_NODES-1:0] reached;
  logic               changed;
  logic               saturated;
  logic               negative;

  logic signed [DIST_W-1:0] nd;
  logic signed [DIST_W-1:0] dist_h;
  logic               nd_sat;
  logic               edge_ok;
  logic               reach_h;

  logic [COUNT_W-1:0] n_eff;
  logic               start_ok;

  logic               edge_we;
  logic [EDGE_W-1:0]  edge_rdata;
  logic [NODE_W-1:0]  e_tail;
  logic [NODE_W-1:0]  e_head;
  logic signed [COST_W-1:0] e_cost;

  logic               dist_we;
  logic [NW-1:0]      dist_waddr;
  logic [DIST_W-1:0]  dist_wdata;
  logic [NW-1:0]      dist_raddr_a;
  logic [DIST_W-1:0]  dist_rdata_a;
  logic [DIST_W-1:0]  dist_rdata_b;

  logic signed [DIST_W:0]   sum;
  logic signed [DIST_W-1:0] sum_sat;
  logic               sum_ovf;
  logic               do_update;
  logic               last_edge;

  logic               out_valid;
  logic [NODE_W-1:0]  out_index;
  logic [DIST_W-1:0]  out_dist;
  logic               out_reach;
  logic               out_neg;
  logic               out_last;

  always_comb begin
    if (node_count == '0) begin
      n_eff = COUNT_W'(1);
    end else if (node_count > COUNT_W'(MAX_NODES)) begin
      n_eff = COUNT_W'(MAX_NODES);
    end else begin
      n_eff = node_count;
    end
  end

  assign start_ok  = ({1'b0, start_node} < n_eff);
  assign cmd_ready = (state == S_IDLE);

  assign e_tail = edge_rdata[NODE_W-1:0];
  assign e_head = edge_rdata[2*NODE_W-1:NODE_W];
  assign e_cost = edge_rdata[EDGE_W-1:2*NODE_W];

  assign edge_we = (state == S_IDLE) && cmd_valid && (cmd.op == CMD_APPEND) &&
                   (edge_total < ETW'(MAX_EDGES));

  ssp_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk   (clk),
    .we    (edge_we),
    .waddr (edge_total[EAW-1:0]),
    .wdata ({cmd.weight, cmd.dst, cmd.src}),
    .raddr (edge_idx),
    .rdata (edge_rdata)
  );

  // Two copies of the distance table so that tail and head read in the same cycle.
  assign dist_raddr_a = (state == S_ERD || state == S_ELD) ? emit_idx : e_tail[NW-1:0];

  assign do_update = edge_ok && (!reach_h || (nd < dist_h));

  always_comb begin
    if (state == S_IDLE) begin
      dist_we    = cmd_valid && (cmd.op == CMD_RUN) && start_ok;
      dist_waddr = start_node[NW-1:0];
      dist_wdata = '0;
    end else begin
      dist_we    = (state == S_CMP) && do_update;
      dist_waddr = e_head[NW-1:0];
      dist_wdata = nd;
    end
  end

  ssp_ram #(.WIDTH(DIST_W), .DEPTH(MAX_NODES)) u_dist_a (
    .clk   (clk),
    .we    (dist_we),
    .waddr (dist_waddr),
    .wdata (dist_wdata),
    .raddr (dist_raddr_a),
    .rdata (dist_rdata_a)
  );

  ssp_ram #(.WIDTH(DIST_W), .DEPTH(MAX_NODES)) u_dist_b (
    .clk   (clk),
    .we    (dist_we),
    .waddr (dist_waddr),
    .wdata (dist_wdata),
    .raddr (e_head[NW-1:0]),
    .rdata (dist_rdata_b)
  );

  always_comb begin
    sum     = {dist_rdata_a[DIST_W-1], dist_rdata_a} +
              {{(DIST_W + 1 - COST_W){e_cost[COST_W-1]}}, e_cost};
    sum_ovf = (sum[DIST_W] != sum[DIST_W-1]);
    if (!sum_ovf) begin
      sum_sat = sum[DIST_W-1:0];
    end else if (sum[DIST_W]) begin
      sum_sat = DIST_MIN;
    end else begin
      sum_sat = DIST_MAX;
    end
  end

  assign last_edge = (CW'(edge_idx) + CW'(1)) == CW'(edge_total);

  always_ff @(posedge clk) begin
    if (state == S_ADD) begin
      nd      <= sum_sat;
      nd_sat  <= sum_ovf;
      dist_h  <= dist_rdata_b;
      reach_h <= reached[e_head[NW-1:0]];
      edge_ok <= ({1'b0, e_tail} < n_run) && ({1'b0, e_head} < n_run) &&
                 reached[e_tail[NW-1:0]];
    end
    if (state == S_ELD && (!out_valid || m_tready)) begin
      out_index <= NODE_W'(emit_idx);
      out_reach <= reached[emit_idx];
      out_dist  <= reached[emit_idx] ? dist_rdata_a : '0;
      out_neg   <= negative;
      out_last  <= (COUNT_W'(emit_idx) + COUNT_W'(1)) == n_run;
    end
    if (rst) begin
      state      <= S_IDLE;
      edge_total <= '0;
      edge_idx   <= '0;
      n_run      <= COUNT_W'(1);
      pass       <= '0;
      emit_idx   <= '0;
      reached    <= '0;
      changed    <= 1'b0;
      saturated  <= 1'b0;
      negative   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (state == S_ELD && (!out_valid || m_tready)) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            unique case (cmd.op)
              CMD_CLEAR: begin
                edge_total <= '0;
              end
              CMD_APPEND: begin
                if (edge_we) begin
                  edge_total <= edge_total + ETW'(1);
                end
              end
              CMD_RUN: begin
                n_run     <= n_eff;
                pass      <= '0;
                saturated <= 1'b0;
                reached   <= start_ok ? (MAX_NODES'(1) << start_node[NW-1:0]) : '0;
                state     <= S_PSTART;
              end
              default: begin
              end
            endcase
          end
        end
        S_PSTART: begin
          changed  <= 1'b0;
          edge_idx <= '0;
          if (edge_total == '0) begin
            negative <= saturated;
            emit_idx <= '0;
            state    <= S_ERD;
          end else begin
            state <= S_EREAD;
          end
        end
        S_EREAD: state <= S_NREAD;
        S_NREAD: state <= S_ADD;
        S_ADD:   state <= S_CMP;
        S_CMP: begin
          if (edge_ok && nd_sat) begin
            saturated <= 1'b1;
          end
          if (do_update) begin
            reached[e_head[NW-1:0]] <= 1'b1;
            changed <= 1'b1;
          end
          if (last_edge) begin
            state <= S_PEND;
          end else begin
            edge_idx <= edge_idx + EAW'(1);
            state    <= S_EREAD;
          end
        end
        S_PEND: begin
          if (!changed || (pass + COUNT_W'(1)) == n_run) begin
            negative <= changed || saturated;
            emit_idx <= '0;
            state    <= S_ERD;
          end else begin
            pass  <= pass + COUNT_W'(1);
            state <= S_PSTART;
          end
        end
        S_ERD: state <= S_ELD;
        S_ELD: begin
          if (!out_valid || m_tready) begin
            if ((COUNT_W'(emit_idx) + COUNT_W'(1)) == n_run) begin
              state <= S_IDLE;
            end else begin
              emit_idx <= emit_idx + NW'(1);
              state    <= S_ERD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_neg, out_reach, out_dist, out_index};
  assign m_tlast  = out_last;

endmodule

/* rtl/core/single_source_shortest_path.sv */
// Clear and append are handled in the back end's idle state; the front queue holds two commands.
// A run repeats passes over the edge store; each edge goes through edge read, distance read,
// saturating add, then compare and write back, in states S_EREAD, S_NREAD, S_ADD and S_CMP.
// Each result is read from the distance table (S_ERD) before it is registered for output (S_ELD).
// Synchronous reset empties the queue and the edge store and sets node_count to 64 and
// start_node to 0; memories are not cleared and need no sweep.
module single_source_shortest_path
  import ssp_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEF,
  parameter int MAX_EDGES = MAX_EDGES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_W-1:0]   s_tdata,   // src_node, dst_node, weight, zero pad
  input  logic [1:0]        s_tuser,   // command
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata,   // node_index, distance, reachable, negative_cycle
  output logic              m_tlast,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [COUNT_W-1:0] node_count;
  logic [NODE_W-1:0]  start_node;
  logic               cfg_write;
  logic               cmd_valid;
  logic               cmd_ready;
  cmd_t               cmd;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_COUNT_RST;
      start_node <= '0;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_NODE_COUNT: node_count <= pwdata[COUNT_W-1:0];
        REG_START_NODE: start_node <= pwdata[NODE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_NODE_COUNT: prdata = 32'(node_count);
      REG_START_NODE: prdata = 32'(start_node);
      default:        prdata = '0;
    endcase
  end

  ssp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  ssp_back #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .node_count (node_count),
    .start_node (start_node),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule

/* rtl/core/ssp_checker.sv */
module ssp_checker
  import ssp_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata,
  input logic             m_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result beat changed while stalled");

  a_rst_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid straight after reset");

  // An unreached node always reports a zero distance.
  a_unreached_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[DIST_W+NODE_W] |-> m_tdata[DIST_W+NODE_W-1:NODE_W] == '0)
    else $error("unreached node with non-zero distance");

endmodule

bind single_source_shortest_path ssp_checker u_ssp_checker (.*);
